[rtl/sbc_pkg.sv]
`default_nettype none

package sbc_pkg;

    // Sample and counter widths.
    localparam int ADC_BITS   = 12;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 16;

    // Field widths of the item streams.
    localparam int OP_BITS      = 3;
    localparam int MODE_BITS    = 3;
    localparam int STEP_BITS    = 3;
    localparam int PHASE_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;

    // Input data carries the three phase samples, padded to whole bytes.
    localparam int S_FIELD_BITS = 3 * ADC_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;

    // Result item layout, packed from the lowest bit up.
    localparam int M_FIELD_BITS = MODE_BITS + STEP_BITS + 2 * PHASE_BITS + 3 + COUNT_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_TDATA_BITS - M_FIELD_BITS;

    // Sum of three samples and three times one sample both fit here.
    localparam int SUM_BITS = ADC_BITS + 3;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_IDLE  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_ALIGN = 3'd2;
    localparam logic [OP_BITS-1:0] OP_RAMP  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_FAULT = 3'd4;

    // Mode codes.
    localparam logic [MODE_BITS-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_ALIGN  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_RAMP   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_CLOSED = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_FAULT  = 3'd4;

    // Step numbers at either end of the sequence.
    localparam logic [STEP_BITS-1:0] STEP_FIRST = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_LAST  = 3'd6;

    // Phase codes.
    localparam logic [PHASE_BITS-1:0] PH_A = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_B = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_C = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_START = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_END   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALL      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HANDOVER   = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_BITS-1:0] RAMP_START_RST = 16'd200;
    localparam logic [CFG_BITS-1:0] RAMP_END_RST   = 16'd25;
    localparam logic [CFG_BITS-1:0] STALL_RST      = 16'd2000;
    localparam logic [CFG_BITS-1:0] HANDOVER_RST   = 16'd10;

    // One result item; the first member sits in the highest bits.
    typedef struct packed {
        logic [M_PAD_BITS-1:0] pad;
        logic                  stalled;
        logic [COUNT_BITS-1:0] step_period;
        logic                  commutated;
        logic                  bridge_enabled;
        logic [PHASE_BITS-1:0] ground_phase;
        logic [PHASE_BITS-1:0] pwm_phase;
        logic [STEP_BITS-1:0]  step;
        logic [MODE_BITS-1:0]  mode;
    } result_t;

    // Counter increment that holds at the top value.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == {COUNT_BITS{1'b1}}) ? v : COUNT_BITS'(v + 1'b1);
        return r;
    endfunction

    // High-side phase of each step.
    function automatic logic [PHASE_BITS-1:0] hi_of_step(input logic [STEP_BITS-1:0] s);
        logic [PHASE_BITS-1:0] r;
        unique case (s)
            3'd3, 3'd4: r = PH_B;
            3'd5, 3'd6: r = PH_C;
            default:    r = PH_A;
        endcase
        return r;
    endfunction

    // Low-side phase of each step.
    function automatic logic [PHASE_BITS-1:0] lo_of_step(input logic [STEP_BITS-1:0] s);
        logic [PHASE_BITS-1:0] r;
        unique case (s)
            3'd2, 3'd3: r = PH_C;
            3'd4, 3'd5: r = PH_A;
            default:    r = PH_B;
        endcase
        return r;
    endfunction

    // Phase left floating in each step.
    function automatic logic [PHASE_BITS-1:0] float_of_step(input logic [STEP_BITS-1:0] s);
        logic [PHASE_BITS-1:0] r;
        unique case (s)
            3'd1, 3'd4: r = PH_C;
            3'd2, 3'd5: r = PH_B;
            default:    r = PH_A;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/sensorless_bldc_commutator.sv]
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tuser operation, tdata phase samples
// m_*       out        m_tvalid / m_tready  tdata one result item
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An accepted item waits in the input register while the step logic computes
// its result, which is then taken into the result register that drives m_tvalid.
// One item per cycle is sustained while the result side keeps taking items.
// Reset (rst_n low) returns the sequencer to idle at step one, clears all
// counters and loads the configuration registers with their default values.
// A stalled result holds the result register; an empty input register still
// takes one further item before s_tready drops. cfg_ready is always high.
`default_nettype none

module sensorless_bldc_commutator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // phase_a_volts, phase_b_volts, phase_c_volts, zero padding
    input  logic [sbc_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // operation
    input  logic [sbc_pkg::OP_BITS-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mode, step, pwm_phase, ground_phase, bridge_enabled, commutated,
    // step_period, stalled, zero padding
    output logic [sbc_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sbc_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int AB = sbc_pkg::ADC_BITS;
    localparam int CB = sbc_pkg::COUNT_BITS;

    // Configuration registers.
    logic [sbc_pkg::CFG_BITS-1:0] ramp_start_reg, ramp_end_reg, stall_limit_reg, handover_reg;

    // Input register.
    logic                         in_vld_reg;
    logic [sbc_pkg::OP_BITS-1:0]  in_op_reg;
    logic [AB-1:0]                in_a_reg, in_b_reg, in_c_reg;

    // Sequencer state.
    logic [sbc_pkg::MODE_BITS-1:0] mode_reg, mode_next;
    logic [sbc_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic [CB-1:0] ramp_ticks_reg, ramp_ticks_next;
    logic [CB-1:0] ramp_delay_reg, ramp_delay_next;
    logic [CB-1:0] stall_ticks_reg, stall_ticks_next;
    logic [CB-1:0] step_ticks_reg, step_ticks_next;
    logic [CB-1:0] last_period_reg, last_period_next;
    logic [CB-1:0] blank_ticks_reg, blank_ticks_next;

    // Result register.
    logic               out_vld_reg;
    sbc_pkg::result_t   out_reg, out_next;

    // Step logic helpers.
    logic                             s_fire, proc_fire;
    logic                             com, stl;
    logic [sbc_pkg::STEP_BITS-1:0]    step_adv;
    logic [CB-1:0]                    ramp_inc, stall_inc, count_inc;
    logic [CB-1:0]                    quarter_ramp, quarter_closed;
    logic [sbc_pkg::PHASE_BITS-1:0]   float_ph;
    logic [AB-1:0]                    fv;
    logic [sbc_pkg::SUM_BITS-1:0]     volt_sum, fv_x3;
    logic                             crossing;

    assign s_fire    = s_tvalid && s_tready;
    assign proc_fire = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || proc_fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_start_reg  <= sbc_pkg::RAMP_START_RST;
            ramp_end_reg    <= sbc_pkg::RAMP_END_RST;
            stall_limit_reg <= sbc_pkg::STALL_RST;
            handover_reg    <= sbc_pkg::HANDOVER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sbc_pkg::CFG_RAMP_START: ramp_start_reg  <= cfg_data;
                sbc_pkg::CFG_RAMP_END:   ramp_end_reg    <= cfg_data;
                sbc_pkg::CFG_STALL:      stall_limit_reg <= cfg_data;
                sbc_pkg::CFG_HANDOVER:   handover_reg    <= cfg_data;
            endcase
        end
    end

    // Input register: holds one item until the step logic takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg <= s_tuser;
            in_a_reg  <= s_tdata[AB-1:0];
            in_b_reg  <= s_tdata[2*AB-1:AB];
            in_c_reg  <= s_tdata[3*AB-1:2*AB];
        end
    end

    // Crossing test against the virtual neutral. The floating phase lies
    // below floor(sum/3) exactly when 3*fv+3 <= sum, above it when 3*fv > sum.
    assign float_ph = sbc_pkg::float_of_step(step_reg);
    always_comb
    begin
        unique case (float_ph)
            sbc_pkg::PH_B: fv = in_b_reg;
            sbc_pkg::PH_C: fv = in_c_reg;
            default:       fv = in_a_reg;
        endcase
    end
    assign volt_sum = sbc_pkg::SUM_BITS'(in_a_reg) + sbc_pkg::SUM_BITS'(in_b_reg)
                    + sbc_pkg::SUM_BITS'(in_c_reg);
    assign fv_x3    = (sbc_pkg::SUM_BITS'(fv) << 1) + sbc_pkg::SUM_BITS'(fv);
    assign crossing = step_reg[0] ? (sbc_pkg::SUM_BITS'(fv_x3 + 3'd3) <= volt_sum)
                                  : (fv_x3 > volt_sum);

    // Next step, saturated counter increments and quarter-period blanking values.
    assign step_adv       = (step_reg >= sbc_pkg::STEP_LAST) ? sbc_pkg::STEP_FIRST
                                                             : step_reg + 1'b1;
    assign ramp_inc       = sbc_pkg::sat_inc(ramp_ticks_reg);
    assign stall_inc      = sbc_pkg::sat_inc(stall_ticks_reg);
    assign count_inc      = sbc_pkg::sat_inc(step_ticks_reg);
    assign quarter_ramp   = (step_ticks_reg[CB-1:2] == '0) ? CB'(1) : (step_ticks_reg >> 2);
    assign quarter_closed = (count_inc[CB-1:2] == '0) ? CB'(1) : (count_inc >> 2);

    // Sequencer step for one item.
    always_comb
    begin
        mode_next        = mode_reg;
        step_next        = step_reg;
        ramp_ticks_next  = ramp_ticks_reg;
        ramp_delay_next  = ramp_delay_reg;
        stall_ticks_next = stall_ticks_reg;
        step_ticks_next  = step_ticks_reg;
        last_period_next = last_period_reg;
        blank_ticks_next = blank_ticks_reg;
        com              = 1'b0;
        stl              = 1'b0;
        unique case (in_op_reg)
            sbc_pkg::OP_IDLE:  mode_next = sbc_pkg::MODE_IDLE;
            sbc_pkg::OP_ALIGN: mode_next = sbc_pkg::MODE_ALIGN;
            sbc_pkg::OP_FAULT: mode_next = sbc_pkg::MODE_FAULT;
            sbc_pkg::OP_RAMP:
            begin
                mode_next        = sbc_pkg::MODE_RAMP;
                ramp_ticks_next  = '0;
                step_ticks_next  = '0;
                stall_ticks_next = '0;
                ramp_delay_next  = ramp_start_reg;
            end
            sbc_pkg::OP_TICK:
            begin
                if (mode_reg == sbc_pkg::MODE_RAMP)
                begin
                    // Blind commutation once the delay has run out.
                    if (ramp_inc >= ramp_delay_reg)
                    begin
                        com              = 1'b1;
                        ramp_ticks_next  = '0;
                        last_period_next = step_ticks_reg;
                        step_ticks_next  = '0;
                        step_next        = step_adv;
                        stall_ticks_next = '0;
                        if (ramp_delay_reg > ramp_end_reg)
                        begin
                            ramp_delay_next  = ramp_delay_reg - 1'b1;
                            blank_ticks_next = quarter_ramp;
                        end
                        else
                        begin
                            mode_next        = sbc_pkg::MODE_CLOSED;
                            blank_ticks_next = handover_reg;
                        end
                    end
                    else
                    begin
                        ramp_ticks_next = ramp_inc;
                    end
                end
                else if (mode_reg == sbc_pkg::MODE_CLOSED)
                begin
                    step_ticks_next = count_inc;
                    if (stall_inc > stall_limit_reg)
                    begin
                        mode_next        = sbc_pkg::MODE_IDLE;
                        stall_ticks_next = '0;
                        stl              = 1'b1;
                    end
                    else if (blank_ticks_reg != '0)
                    begin
                        stall_ticks_next = stall_inc;
                        blank_ticks_next = blank_ticks_reg - 1'b1;
                    end
                    else if (crossing)
                    begin
                        com              = 1'b1;
                        last_period_next = count_inc;
                        step_ticks_next  = '0;
                        step_next        = step_adv;
                        stall_ticks_next = '0;
                        blank_ticks_next = quarter_closed;
                    end
                    else
                    begin
                        stall_ticks_next = stall_inc;
                    end
                end
            end
            default:
            begin
                // Unused operation codes leave the state alone.
            end
        endcase
    end

    // Result item from the updated state.
    always_comb
    begin
        out_next                = '0;
        out_next.mode           = mode_next;
        out_next.step           = step_next;
        out_next.pwm_phase      = sbc_pkg::hi_of_step(step_next);
        out_next.ground_phase   = sbc_pkg::lo_of_step(step_next);
        out_next.bridge_enabled = (mode_next == sbc_pkg::MODE_ALIGN)
                               || (mode_next == sbc_pkg::MODE_RAMP)
                               || (mode_next == sbc_pkg::MODE_CLOSED);
        out_next.commutated     = com;
        out_next.step_period    = last_period_next;
        out_next.stalled        = stl;
    end

    // State update, one item per processing cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= sbc_pkg::MODE_IDLE;
            step_reg        <= sbc_pkg::STEP_FIRST;
            ramp_ticks_reg  <= '0;
            ramp_delay_reg  <= '0;
            stall_ticks_reg <= '0;
            step_ticks_reg  <= '0;
            last_period_reg <= '0;
            blank_ticks_reg <= '0;
        end
        else if (proc_fire)
        begin
            mode_reg        <= mode_next;
            step_reg        <= step_next;
            ramp_ticks_reg  <= ramp_ticks_next;
            ramp_delay_reg  <= ramp_delay_next;
            stall_ticks_reg <= stall_ticks_next;
            step_ticks_reg  <= step_ticks_next;
            last_period_reg <= last_period_next;
            blank_ticks_reg <= blank_ticks_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sbc_checker.sv]
`default_nettype none

module sbc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [sbc_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    sbc_pkg::result_t res;
    assign res = m_tdata;

    // A result waiting on the output holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // The bridge is driven exactly in align, ramp-up and closed loop.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.bridge_enabled == ((res.mode == sbc_pkg::MODE_ALIGN)
            || (res.mode == sbc_pkg::MODE_RAMP) || (res.mode == sbc_pkg::MODE_CLOSED)))
        else $error("bridge enable disagrees with mode");

    // A stall timeout lands in idle and never commutates on the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.stalled |-> res.mode == sbc_pkg::MODE_IDLE && !res.commutated)
        else $error("stall result inconsistent");

    // Commutation only happens in ramp-up or closed loop.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.commutated
            |-> res.mode == sbc_pkg::MODE_RAMP || res.mode == sbc_pkg::MODE_CLOSED)
        else $error("commutation outside a running mode");

    // The step stays in range and drives two different phases.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.step >= sbc_pkg::STEP_FIRST && res.step <= sbc_pkg::STEP_LAST
            && res.pwm_phase != res.ground_phase)
        else $error("step or phase pair out of range");

endmodule

bind sensorless_bldc_commutator sbc_checker u_sbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
